// File: rtl/hcl_pkg.sv
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared types and constants for the hit clustering block: the hit and
// cluster payloads, the queue entry and the configuration register indexes.
// ----------------------------------------------------------------------------
package hcl_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_HITS   = 2'd0;
  localparam logic [1:0] CFG_WINDOW     = 2'd1;
  localparam logic [1:0] CFG_CHAN_GAP   = 2'd2;

  localparam int CFG_DATA_W = 32;
  localparam int BOUND_W    = 18;

  // Reset values of the configuration registers
  localparam logic [15:0] MIN_HITS_RST = 16'd2;
  localparam logic [31:0] WINDOW_RST   = 32'd8000;
  localparam logic [15:0] CHAN_GAP_RST = 16'd50;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [31:0] SUM_MAX   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] hit_channel;
    logic [63:0] hit_start_time;
    logic [63:0] hit_peak_time;
    logic [31:0] hit_integral;
    logic [15:0] hit_peak_adc;
    logic [15:0] hit_detector;
  } hit_t;

  typedef struct packed {
    logic [15:0] first_channel_out;
    logic [15:0] last_channel_out;
    logic [63:0] first_time_out;
    logic [63:0] last_time_out;
    logic [63:0] peak_time_out;
    logic [15:0] peak_channel_out;
    logic [15:0] peak_adc_out;
    logic [31:0] integral_out;
    logic [15:0] detector_out;
    logic [15:0] hit_count_out;
  } clu_t;

  // Hit plus its own channel reach, as queued between front and back
  typedef struct packed {
    hit_t                      hit;
    logic signed [BOUND_W-1:0] lo;
    logic signed [BOUND_W-1:0] hi;
  } qent_t;

endpackage

// File: rtl/hcl_front.sv
// ----------------------------------------------------------------------------
// hcl_front
// Front end: turns an incoming hit into a queue entry carrying the channel
// reach (channel minus and plus the gap) that the hit would add to a window.
// ----------------------------------------------------------------------------
module hcl_front (
  input  hcl_pkg::hit_t  hit,
  input  logic [15:0]    chan_gap,
  output hcl_pkg::qent_t ent
);

  logic signed [hcl_pkg::BOUND_W-1:0] ch_s;
  logic signed [hcl_pkg::BOUND_W-1:0] gap_s;

  // Extend channel and gap to the signed bound width
  assign ch_s  = $signed({2'b00, hit.hit_channel});
  assign gap_s = $signed({2'b00, chan_gap});

  // Compute the reach of this hit
  assign ent.hit = hit;
  assign ent.lo  = ch_s - gap_s;
  assign ent.hi  = ch_s + gap_s;

endmodule

// File: rtl/hcl_queue.sv
// ----------------------------------------------------------------------------
// hcl_queue
// Two-entry queue between the front end and the cluster engine, so that
// either side can stall without holding the other.
// ----------------------------------------------------------------------------
module hcl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hcl_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output hcl_pkg::qent_t head
);

  hcl_pkg::qent_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     fill_r, fill_nxt;
  logic           do_push;
  logic           do_pop;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 2'd2)
    else $error("queue fill level out of range");

  a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> fill_r == $past(fill_r) + 2'd1)
    else $error("queue fill did not grow on push");

  a_fill_down: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> fill_r == $past(fill_r) - 2'd1)
    else $error("queue fill did not shrink on pop");

endmodule

// File: rtl/hcl_back.sv
// ----------------------------------------------------------------------------
// hcl_back
// Cluster engine: keeps the open cluster as running sums, closes it when a
// hit falls past the time window, and holds a closed cluster in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module hcl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    min_hits,
  input  logic [31:0]    window_ticks,
  input  logic           q_not_empty,
  input  hcl_pkg::qent_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output hcl_pkg::clu_t  out_data
);

  // Open cluster state
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] first_ch_r, first_ch_nxt;
  logic [63:0] first_time_r, first_time_nxt;
  logic [15:0] det_r, det_nxt;
  logic [15:0] last_ch_r, last_ch_nxt;
  logic [63:0] last_time_r, last_time_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [15:0] best_adc_r, best_adc_nxt;
  logic [15:0] best_ch_r, best_ch_nxt;
  logic [63:0] best_time_r, best_time_nxt;
  logic signed [hcl_pkg::BOUND_W-1:0] low_r, low_nxt;
  logic signed [hcl_pkg::BOUND_W-1:0] high_r, high_nxt;

  logic          out_valid_r, out_valid_nxt;
  hcl_pkg::clu_t out_data_r, out_data_nxt;

  hcl_pkg::hit_t                      h;
  logic [63:0]                        dt;
  logic                               late;
  logic                               open_new;
  logic                               in_window;
  logic                               emit;
  logic [32:0]                        sum_wide;
  logic signed [hcl_pkg::BOUND_W-1:0] ch_s;

  assign h         = q_head.hit;
  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign dt        = h.hit_start_time - first_time_r;
  assign late      = (dt > {32'd0, window_ticks});
  assign open_new  = (cnt_r == 16'd0) || late;
  assign ch_s      = $signed({2'b00, h.hit_channel});
  assign in_window = (ch_s <= high_r) && (ch_s >= low_r);
  assign emit      = q_pop && (cnt_r != 16'd0) && late && (cnt_r >= min_hits);
  assign sum_wide  = {1'b0, sum_r} + {1'b0, h.hit_integral};

  // Update the open cluster from the popped hit
  always_comb begin
    cnt_nxt        = cnt_r;
    first_ch_nxt   = first_ch_r;
    first_time_nxt = first_time_r;
    det_nxt        = det_r;
    last_ch_nxt    = last_ch_r;
    last_time_nxt  = last_time_r;
    sum_nxt        = sum_r;
    best_adc_nxt   = best_adc_r;
    best_ch_nxt    = best_ch_r;
    best_time_nxt  = best_time_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    if (q_pop) begin
      if (open_new) begin
        cnt_nxt        = 16'd1;
        first_ch_nxt   = h.hit_channel;
        first_time_nxt = h.hit_start_time;
        det_nxt        = h.hit_detector;
        last_ch_nxt    = h.hit_channel;
        last_time_nxt  = h.hit_start_time;
        sum_nxt        = h.hit_integral;
        low_nxt        = q_head.lo;
        high_nxt       = q_head.hi;
        if (h.hit_peak_adc != 16'd0) begin
          best_adc_nxt  = h.hit_peak_adc;
          best_ch_nxt   = h.hit_channel;
          best_time_nxt = h.hit_peak_time;
        end else begin
          best_adc_nxt  = 16'd0;
          best_ch_nxt   = 16'd0;
          best_time_nxt = 64'd0;
        end
      end else if (in_window) begin
        if (cnt_r != hcl_pkg::COUNT_MAX) begin
          cnt_nxt = cnt_r + 16'd1;
        end
        last_ch_nxt   = h.hit_channel;
        last_time_nxt = h.hit_start_time;
        sum_nxt       = sum_wide[32] ? hcl_pkg::SUM_MAX : sum_wide[31:0];
        // Strictly larger peak replaces; a tie keeps the earlier hit
        if (h.hit_peak_adc > best_adc_r) begin
          best_adc_nxt  = h.hit_peak_adc;
          best_ch_nxt   = h.hit_channel;
          best_time_nxt = h.hit_peak_time;
        end
        if (q_head.lo < low_r) begin
          low_nxt = q_head.lo;
        end
        if (q_head.hi > high_r) begin
          high_nxt = q_head.hi;
        end
      end
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt                  = 1'b1;
      out_data_nxt.first_channel_out = first_ch_r;
      out_data_nxt.last_channel_out  = last_ch_r;
      out_data_nxt.first_time_out    = first_time_r;
      out_data_nxt.last_time_out     = last_time_r;
      out_data_nxt.peak_time_out     = best_time_r;
      out_data_nxt.peak_channel_out  = best_ch_r;
      out_data_nxt.peak_adc_out      = best_adc_r;
      out_data_nxt.integral_out      = sum_r;
      out_data_nxt.detector_out      = det_r;
      out_data_nxt.hit_count_out     = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload state
  always_ff @(posedge clk) begin
    first_ch_r   <= first_ch_nxt;
    first_time_r <= first_time_nxt;
    det_r        <= det_nxt;
    last_ch_r    <= last_ch_nxt;
    last_time_r  <= last_time_nxt;
    sum_r        <= sum_nxt;
    best_adc_r   <= best_adc_nxt;
    best_ch_r    <= best_ch_nxt;
    best_time_r  <= best_time_nxt;
    low_r        <= low_nxt;
    high_r       <= high_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_open_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> cnt_r != 16'd0)
    else $error("no open cluster after a hit was taken");

  a_emit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (cnt_r == 16'd1) && out_valid_r)
    else $error("closing a cluster did not open a new one");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 16'd0) |-> (low_r <= high_r))
    else $error("channel window bounds crossed");

endmodule

// File: rtl/hit_cluster_by_time_and_channel.sv
// ----------------------------------------------------------------------------
// hit_cluster_by_time_and_channel
// Groups detector hits into clusters by time window and channel proximity.
//
// Hits enter on the in_ channel (valid/stall); closed clusters that hold at
// least min_hits hits leave on the out_ channel (valid/stall). Registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce;
// index 0 min_hits, 1 window_ticks, 2 max_channel_gap.
// One hit is taken per cycle while in_stall is low. A hit is written into
// the two-entry queue and is folded into the open cluster when the engine
// pops it; the cluster it closes is loaded into the output register at that
// same edge, which raises out_valid. The running-sum update in the cluster
// engine sets the rate of one hit per cycle while the output does not stall.
// Reset returns registers to 2, 8000 and 50, empties the queue and the
// output register, and leaves no cluster open. When the receiver stalls the
// result holds in the output register and the engine stops taking hits; the
// queue fills and in_stall rises within two more hits. The open cluster is
// never flushed.
// ----------------------------------------------------------------------------
module hit_cluster_by_time_and_channel (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  hcl_pkg::hit_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output hcl_pkg::clu_t                      out_data,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [hcl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [15:0]    min_hits_r;
  logic [31:0]    window_r;
  logic [15:0]    chan_gap_r;
  hcl_pkg::qent_t f_ent;
  hcl_pkg::qent_t q_head;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;

  // Write configuration registers; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hits_r <= hcl_pkg::MIN_HITS_RST;
      window_r   <= hcl_pkg::WINDOW_RST;
      chan_gap_r <= hcl_pkg::CHAN_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcl_pkg::CFG_MIN_HITS: min_hits_r <= cfg_wdata[15:0];
        hcl_pkg::CFG_WINDOW:   window_r   <= cfg_wdata[31:0];
        hcl_pkg::CFG_CHAN_GAP: chan_gap_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  hcl_front u_front (
    .hit      (in_data),
    .chan_gap (chan_gap_r),
    .ent      (f_ent)
  );

  hcl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (f_ent),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  hcl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .min_hits     (min_hits_r),
    .window_ticks (window_r),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
